// ===== sv/metaball_density_splatter_defines.svh =====
// ----------------------------------------------------------------------------
// metaball density splatter assertion macros
// shorthand for the concurrent checks on the port behaviour
// ----------------------------------------------------------------------------
`ifndef METABALL_DENSITY_SPLATTER_DEFINES_SVH
`define METABALL_DENSITY_SPLATTER_DEFINES_SVH

// same-cycle implication, held off during reset
`define MBDS_ASSERT_IMP(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MBDS_ASSERT_NXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define MBDS_ASSERT_NXT_ALL(name, ck, ante, cons, msg) \
  name: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mbds_pkg.sv =====
// ----------------------------------------------------------------------------
// mbds_pkg
// types, codes and fixed widths shared by the metaball density splatter
// ----------------------------------------------------------------------------
package mbds_pkg;

  localparam int RADW       = 4;
  localparam int PEAK_W     = 12;
  localparam int DENS_W     = 16;
  localparam int LVL_W      = 3;
  localparam int KIND_W     = 2;
  localparam int COORD_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int Q_W       = 2 * RADW + 1;
  localparam int R2_W      = 2 * RADW;
  localparam int DSQ_W     = 4 * RADW;
  localparam int NUM_W     = PEAK_W + DSQ_W;
  localparam int MUL_AW    = PEAK_W;
  localparam int MUL_BW    = DSQ_W;
  localparam int MUL_PW    = MUL_AW + MUL_BW;
  localparam int DIV_STEPS = PEAK_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [KIND_W-1:0] KIND_CLEAR = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_SPLAT = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_READ  = KIND_W'(2);

  localparam logic [LVL_W-1:0] LVL_EMPTY  = LVL_W'(0);
  localparam logic [LVL_W-1:0] LVL_LIGHT  = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_MID    = LVL_W'(2);
  localparam logic [LVL_W-1:0] LVL_CENTRE = LVL_W'(3);
  localparam logic [LVL_W-1:0] LVL_FOAM   = LVL_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FILL   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MID    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_FOAM   = CFG_IDX_W'(5);

  localparam logic [RADW-1:0]   RST_RADIUS = RADW'(11);
  localparam logic [PEAK_W-1:0] RST_PEAK   = PEAK_W'(1320);
  localparam logic [DENS_W-1:0] RST_FILL   = DENS_W'(405);
  localparam logic [DENS_W-1:0] RST_LIGHT  = DENS_W'(950);
  localparam logic [DENS_W-1:0] RST_MID    = DENS_W'(1500);
  localparam logic [DENS_W-1:0] RST_FOAM   = DENS_W'(1900);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } cmd_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic [LVL_W-1:0]  level;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [RADW-1:0]   adx;
    logic [RADW-1:0]   ady;
    logic [RADW-1:0]   r;
    logic [PEAK_W-1:0] peak;
  } kg_req_t;

  typedef struct packed {
    logic              done;
    logic [PEAK_W-1:0] weight;
  } kg_rsp_t;

endpackage

// ===== sv/metaball_density_splatter.sv =====
// ----------------------------------------------------------------------------
// metaball_density_splatter
// density grid with a radial splat kernel, built by a shared weight unit
// ----------------------------------------------------------------------------
// channel  signals                        transfer
// cmd      start, cmd, busy               start high while busy low
// result   done, result                   done high for one cycle
// config   cfg_we, cfg_index, cfg_data    cfg_we high, taken at once
//
// read: address state, then data state, then the result; unused kind: answered straight from idle
// splat: setup and base states, then one clipped kernel cell read-modify-write a cycle, then a drain state
// clear: one grid cell zeroed a cycle over all GRID_W*GRID_H cells, and when
//   the radius changed to a non-zero value, the kernel is rebuilt with one
//   weight-unit request per cell of the (2r+1)^2 kernel, computed by the
//   weight unit's multiplier and 12-step divider
// after reset a clearing pass over all GRID_W*GRID_H cells holds busy high
// results cannot be held off; busy stays high until the result is shown
// ----------------------------------------------------------------------------
module metaball_density_splatter import mbds_pkg::*; #(
  parameter int GRID_W     = 83,
  parameter int GRID_H     = 67,
  parameter int MAX_RADIUS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd,
  output logic                  done,
  output res_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KSIDE  = 2 * MAX_RADIUS + 1;
  localparam int KCELLS = KSIDE * KSIDE;
  localparam int FCELLS = GRID_W * GRID_H;
  localparam int KW     = $clog2(KSIDE);
  localparam int KA     = $clog2(KCELLS);
  localparam int FA     = $clog2(FCELLS);
  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);
  localparam int CW0    = (XW > YW) ? XW : YW;
  localparam int SW     = ((CW0 > COORD_W) ? CW0 : COORD_W) + 2;

  localparam logic signed [SW-1:0] XMAX_S = SW'(GRID_W - 1);
  localparam logic signed [SW-1:0] YMAX_S = SW'(GRID_H - 1);
  localparam logic signed [SW-1:0] MRAD_S = SW'(MAX_RADIUS);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_CLEAR  = 11'b00000000010,
    ST_KSETUP = 11'b00000000100,
    ST_BASE   = 11'b00000001000,
    ST_KISSUE = 11'b00000010000,
    ST_KWAIT  = 11'b00000100000,
    ST_SSETUP = 11'b00001000000,
    ST_SRUN   = 11'b00010000000,
    ST_SDRAIN = 11'b00100000000,
    ST_RADDR  = 11'b01000000000,
    ST_RDATA  = 11'b10000000000
  } state_t;

  // configuration
  logic [RADW-1:0]   kernel_radius;
  logic [PEAK_W-1:0] kernel_peak;
  logic [DENS_W-1:0] fill_threshold;
  logic [DENS_W-1:0] light_limit;
  logic [DENS_W-1:0] mid_limit;
  logic [DENS_W-1:0] foam_limit;

  // control
  state_t            state;
  logic              boot;
  logic [RADW-1:0]   built_radius;
  cmd_t              cmd_q;
  logic              inb;
  logic              p_v;
  logic [FA-1:0]     p_addr;

  // rectangle walk over kernel and grid
  logic [KW-1:0]     kx;
  logic [KW-1:0]     ky;
  logic [KW-1:0]     kx_lo;
  logic [KW-1:0]     kx_hi;
  logic [KW-1:0]     ky_hi;
  logic [KA-1:0]     kaddr;
  logic [KA-1:0]     krow;
  logic [FA-1:0]     faddr;
  logic [FA-1:0]     frow;
  logic [XW-1:0]     x_lo;
  logic [YW-1:0]     y_lo;

  // memories
  logic [DENS_W-1:0] field_mem [FCELLS];
  logic [PEAK_W-1:0] kern_mem [KCELLS];
  logic [DENS_W-1:0] fdout;
  logic [PEAK_W-1:0] kdout;

  logic              f_we;
  logic [FA-1:0]     f_waddr;
  logic [DENS_W-1:0] f_wdata;
  logic [FA-1:0]     f_raddr;
  logic [FA-1:0]     rd_addr;
  logic              k_we;

  logic [RADW-1:0]   eff;
  logic              row_end;
  logic              walk_last;
  logic [KA-1:0]     k_base;
  logic [FA-1:0]     f_base;
  logic [DENS_W:0]   sum;
  logic [DENS_W-1:0] sat_sum;
  logic [LVL_W-1:0]  lvl_rd;

  logic signed [SW-1:0] cx_s;
  logic signed [SW-1:0] cy_s;
  logic signed [SW-1:0] r_s;
  logic signed [SW-1:0] xl_s;
  logic signed [SW-1:0] xh_s;
  logic signed [SW-1:0] yl_s;
  logic signed [SW-1:0] yh_s;
  logic signed [SW-1:0] kxl_s;
  logic signed [SW-1:0] kxh_s;
  logic signed [SW-1:0] kyl_s;
  logic signed [SW-1:0] kyh_s;
  logic                 s_empty;

  kg_req_t           kg_req;
  kg_rsp_t           kg_rsp;

  mbds_kgen u_kgen (
    .clk (clk),
    .rst (rst),
    .req (kg_req),
    .rsp (kg_rsp)
  );

  assign busy = (state != ST_IDLE);
  assign eff  = (int'(kernel_radius) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : kernel_radius;

  assign kg_req.start = (state == ST_KISSUE);
  assign kg_req.adx   = (kx >= KW'(MAX_RADIUS)) ? RADW'(kx - KW'(MAX_RADIUS))
                                                : RADW'(KW'(MAX_RADIUS) - kx);
  assign kg_req.ady   = (ky >= KW'(MAX_RADIUS)) ? RADW'(ky - KW'(MAX_RADIUS))
                                                : RADW'(KW'(MAX_RADIUS) - ky);
  assign kg_req.r     = eff;
  assign kg_req.peak  = kernel_peak;

  assign row_end   = (kx == kx_hi);
  assign walk_last = row_end && (ky == ky_hi);
  assign k_base    = KA'(int'(ky) * KSIDE + int'(kx));
  assign f_base    = FA'(int'(y_lo) * GRID_W + int'(x_lo));
  assign rd_addr   = FA'(int'(cmd_q.cell_y) * GRID_W + int'(cmd_q.cell_x));

  // splat rectangle, clipped at the grid edges
  always_comb begin
    cx_s    = SW'(cmd_q.cell_x);
    cy_s    = SW'(cmd_q.cell_y);
    r_s     = SW'(built_radius);
    xl_s    = cx_s - r_s;
    xh_s    = cx_s + r_s;
    yl_s    = cy_s - r_s;
    yh_s    = cy_s + r_s;
    if (xl_s < 0) begin
      xl_s = '0;
    end
    if (yl_s < 0) begin
      yl_s = '0;
    end
    if (xh_s > XMAX_S) begin
      xh_s = XMAX_S;
    end
    if (yh_s > YMAX_S) begin
      yh_s = YMAX_S;
    end
    s_empty = (xl_s > xh_s) || (yl_s > yh_s);
    kxl_s   = xl_s - cx_s + MRAD_S;
    kxh_s   = xh_s - cx_s + MRAD_S;
    kyl_s   = yl_s - cy_s + MRAD_S;
    kyh_s   = yh_s - cy_s + MRAD_S;
  end

  always_comb begin
    sum     = {1'b0, fdout} + (DENS_W + 1)'(kdout);
    sat_sum = sum[DENS_W] ? '1 : sum[DENS_W-1:0];
  end

  always_comb begin
    priority if (fdout < fill_threshold) begin
      lvl_rd = LVL_EMPTY;
    end else if (fdout > foam_limit) begin
      lvl_rd = LVL_FOAM;
    end else if (fdout > mid_limit) begin
      lvl_rd = LVL_CENTRE;
    end else if (fdout > light_limit) begin
      lvl_rd = LVL_MID;
    end else begin
      lvl_rd = LVL_LIGHT;
    end
  end

  assign f_we    = (state == ST_CLEAR) || p_v;
  assign f_waddr = p_v ? p_addr : faddr;
  assign f_wdata = p_v ? sat_sum : '0;
  assign f_raddr = (state == ST_RADDR) ? rd_addr : faddr;
  assign k_we    = (state == ST_KWAIT) && kg_rsp.done;

  always_ff @(posedge clk) begin
    if (f_we) begin
      field_mem[f_waddr] <= f_wdata;
    end
    fdout <= field_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      kern_mem[kaddr] <= kg_rsp.weight;
    end
    kdout <= kern_mem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_radius  <= RST_RADIUS;
      kernel_peak    <= RST_PEAK;
      fill_threshold <= RST_FILL;
      light_limit    <= RST_LIGHT;
      mid_limit      <= RST_MID;
      foam_limit     <= RST_FOAM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS: kernel_radius  <= cfg_data[RADW-1:0];
        CFG_PEAK:   kernel_peak    <= cfg_data[PEAK_W-1:0];
        CFG_FILL:   fill_threshold <= cfg_data[DENS_W-1:0];
        CFG_LIGHT:  light_limit    <= cfg_data[DENS_W-1:0];
        CFG_MID:    mid_limit      <= cfg_data[DENS_W-1:0];
        CFG_FOAM:   foam_limit     <= cfg_data[DENS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      boot         <= 1'b1;
      built_radius <= '0;
      faddr        <= '0;
      done         <= 1'b0;
      p_v          <= 1'b0;
    end else begin
      done <= 1'b0;
      p_v  <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            unique case (cmd.kind)
              KIND_CLEAR: begin
                faddr <= '0;
                state <= ST_CLEAR;
              end
              KIND_SPLAT: state <= ST_SSETUP;
              KIND_READ:  state <= ST_RADDR;
              default: begin
                done   <= 1'b1;
                result <= '0;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (faddr == FA'(FCELLS - 1)) begin
            if (boot) begin
              boot  <= 1'b0;
              state <= ST_IDLE;
            end else if ((eff != built_radius) && (eff != '0)) begin
              state <= ST_KSETUP;
            end else begin
              built_radius <= eff;
              done         <= 1'b1;
              result       <= '0;
              state        <= ST_IDLE;
            end
          end else begin
            faddr <= faddr + 1'b1;
          end
        end
        ST_KSETUP: begin
          kx    <= KW'(MAX_RADIUS) - KW'(eff);
          kx_lo <= KW'(MAX_RADIUS) - KW'(eff);
          ky    <= KW'(MAX_RADIUS) - KW'(eff);
          kx_hi <= KW'(MAX_RADIUS) + KW'(eff);
          ky_hi <= KW'(MAX_RADIUS) + KW'(eff);
          state <= ST_BASE;
        end
        ST_BASE: begin
          krow  <= k_base;
          kaddr <= k_base;
          frow  <= f_base;
          faddr <= f_base;
          state <= (cmd_q.kind == KIND_CLEAR) ? ST_KISSUE : ST_SRUN;
        end
        ST_KISSUE: state <= ST_KWAIT;
        ST_KWAIT: begin
          if (kg_rsp.done) begin
            if (walk_last) begin
              built_radius <= eff;
              done         <= 1'b1;
              result       <= '0;
              state        <= ST_IDLE;
            end else begin
              state <= ST_KISSUE;
              if (row_end) begin
                kx    <= kx_lo;
                ky    <= ky + 1'b1;
                krow  <= krow + KA'(KSIDE);
                kaddr <= krow + KA'(KSIDE);
              end else begin
                kx    <= kx + 1'b1;
                kaddr <= kaddr + 1'b1;
              end
            end
          end
        end
        ST_SSETUP: begin
          if ((built_radius == '0) || s_empty) begin
            done   <= 1'b1;
            result <= '0;
            state  <= ST_IDLE;
          end else begin
            kx    <= kxl_s[KW-1:0];
            kx_lo <= kxl_s[KW-1:0];
            kx_hi <= kxh_s[KW-1:0];
            ky    <= kyl_s[KW-1:0];
            ky_hi <= kyh_s[KW-1:0];
            x_lo  <= xl_s[XW-1:0];
            y_lo  <= yl_s[YW-1:0];
            state <= ST_BASE;
          end
        end
        ST_SRUN: begin
          p_v    <= 1'b1;
          p_addr <= faddr;
          if (walk_last) begin
            state <= ST_SDRAIN;
          end else if (row_end) begin
            kx    <= kx_lo;
            ky    <= ky + 1'b1;
            krow  <= krow + KA'(KSIDE);
            kaddr <= krow + KA'(KSIDE);
            frow  <= frow + FA'(GRID_W);
            faddr <= frow + FA'(GRID_W);
          end else begin
            kx    <= kx + 1'b1;
            kaddr <= kaddr + 1'b1;
            faddr <= faddr + 1'b1;
          end
        end
        ST_SDRAIN: begin
          done   <= 1'b1;
          result <= '0;
          state  <= ST_IDLE;
        end
        ST_RADDR: begin
          inb   <= (int'(cmd_q.cell_x) < GRID_W) && (int'(cmd_q.cell_y) < GRID_H);
          state <= ST_RDATA;
        end
        ST_RDATA: begin
          done           <= 1'b1;
          result.density <= inb ? fdout : '0;
          result.level   <= inb ? lvl_rd : LVL_EMPTY;
          state          <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/mbds_kgen.sv =====
// ----------------------------------------------------------------------------
// mbds_kgen
// kernel weight unit: one shared multiplier and a restoring divider step,
// giving floor(peak*(r2-q)^2/r2^2) for one kernel offset
// ----------------------------------------------------------------------------
module mbds_kgen import mbds_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  kg_req_t req,
  output kg_rsp_t rsp
);

  typedef enum logic [8:0] {
    K_IDLE = 9'b000000001,
    K_SQX  = 9'b000000010,
    K_SQY  = 9'b000000100,
    K_R2   = 9'b000001000,
    K_CHK  = 9'b000010000,
    K_DSQ  = 9'b000100000,
    K_DEN  = 9'b001000000,
    K_NUM  = 9'b010000000,
    K_DIV  = 9'b100000000
  } kstate_t;

  kstate_t             state;
  logic [RADW-1:0]     adx;
  logic [RADW-1:0]     ady;
  logic [RADW-1:0]     r;
  logic [PEAK_W-1:0]   peak;
  logic [Q_W-1:0]      q;
  logic [R2_W-1:0]     r2;
  logic [R2_W-1:0]     diff;
  logic [DSQ_W-1:0]    dsq;
  logic [NUM_W-1:0]    dsh;
  logic [NUM_W-1:0]    rem;
  logic [PEAK_W-1:0]   quo;
  logic [STEP_W-1:0]   step;

  logic [MUL_AW-1:0]   mul_a;
  logic [MUL_BW-1:0]   mul_b;
  logic [MUL_PW-1:0]   mul_p;
  logic                ge;

  always_comb begin
    unique case (state)
      K_SQX:   begin mul_a = MUL_AW'(adx);  mul_b = MUL_BW'(adx);  end
      K_SQY:   begin mul_a = MUL_AW'(ady);  mul_b = MUL_BW'(ady);  end
      K_R2:    begin mul_a = MUL_AW'(r);    mul_b = MUL_BW'(r);    end
      K_DSQ:   begin mul_a = MUL_AW'(diff); mul_b = MUL_BW'(diff); end
      K_DEN:   begin mul_a = MUL_AW'(r2);   mul_b = MUL_BW'(r2);   end
      K_NUM:   begin mul_a = MUL_AW'(peak); mul_b = MUL_BW'(dsq);  end
      default: begin mul_a = '0;            mul_b = '0;            end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign ge    = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= K_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        K_IDLE: begin
          if (req.start) begin
            adx   <= req.adx;
            ady   <= req.ady;
            r     <= req.r;
            peak  <= req.peak;
            state <= K_SQX;
          end
        end
        K_SQX: begin
          q     <= Q_W'(mul_p);
          state <= K_SQY;
        end
        K_SQY: begin
          q     <= q + Q_W'(mul_p);
          state <= K_R2;
        end
        K_R2: begin
          r2    <= R2_W'(mul_p);
          state <= K_CHK;
        end
        K_CHK: begin
          if (q >= Q_W'(r2)) begin
            rsp.done   <= 1'b1;
            rsp.weight <= '0;
            state      <= K_IDLE;
          end else begin
            diff  <= R2_W'(Q_W'(r2) - q);
            state <= K_DSQ;
          end
        end
        K_DSQ: begin
          dsq   <= DSQ_W'(mul_p);
          state <= K_DEN;
        end
        K_DEN: begin
          dsh   <= NUM_W'(mul_p[DSQ_W-1:0]) << (DIV_STEPS - 1);
          state <= K_NUM;
        end
        K_NUM: begin
          rem   <= NUM_W'(mul_p);
          quo   <= '0;
          step  <= '0;
          state <= K_DIV;
        end
        K_DIV: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          quo <= {quo[PEAK_W-2:0], ge};
          dsh <= dsh >> 1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            rsp.done   <= 1'b1;
            rsp.weight <= {quo[PEAK_W-2:0], ge};
            state      <= K_IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: state <= K_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/mbds_checker.sv =====
// ----------------------------------------------------------------------------
// mbds_checker
// port-level checks on the metaball density splatter, bound to the top level
// ----------------------------------------------------------------------------
`include "metaball_density_splatter_defines.svh"

module mbds_checker import mbds_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic done,
  input res_t result
);

  logic take;
  logic known;

  assign take  = start && !busy;
  assign known = (cmd.kind == KIND_CLEAR) || (cmd.kind == KIND_SPLAT) ||
                 (cmd.kind == KIND_READ);

  // reset starts the grid clearing pass
  `MBDS_ASSERT_NXT_ALL(a_reset_sweep, clk, rst, busy, "no clearing pass after reset")

  // a result is only shown once the block is back to idle
  `MBDS_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result strobe while busy")

  // clear, splat and read all keep the block busy after they are taken
  `MBDS_ASSERT_NXT(a_work_busy, clk, rst, take && known, busy, "known transfer not busy")

  // an unused kind answers at once with an empty result
  `MBDS_ASSERT_NXT(a_unused_kind, clk, rst, take && !known, done && !busy && result.density == '0 && result.level == LVL_EMPTY, "unused kind result wrong")

endmodule

bind metaball_density_splatter mbds_checker u_mbds_checker (.*);
